FILE: rtl/tbc_pkg.sv
// Shared types, constants and helpers for the top-three brightest channel mean unit.
// No dependencies.
package tbc_pkg;

    localparam int MAX_CHANNELS = 4096;
    localparam int SAMPLE_W     = 32;
    localparam int CHAN_W       = 13;
    localparam int KEEP         = 3;
    localparam int NFIELDS      = 5;
    localparam int CNT_W        = 2;

    localparam logic [CHAN_W-1:0] CHAN_ONE   = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(MAX_CHANNELS);
    localparam logic [CHAN_W-1:0] CHAN_STOP  = CHAN_W'(MAX_CHANNELS + 1);

    // floor(x / 3) for x below 2**18: x * ceil(2**19 / 3) >> 19
    localparam logic [17:0] RECIP3       = 18'd174763;
    localparam int          RECIP3_SHIFT = 19;

    localparam int F_INTENSITY = 0;
    localparam int F_STOKES_V  = 1;
    localparam int F_LEFT      = 2;
    localparam int F_RIGHT     = 3;
    localparam int F_VELOCITY  = 4;

    typedef enum logic [0:0] {
        CFG_FIRST_CHANNEL = 1'b0,
        CFG_FINAL_CHANNEL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] intensity;
        logic signed [SAMPLE_W-1:0] stokes_v;
        logic signed [SAMPLE_W-1:0] left_hand;
        logic signed [SAMPLE_W-1:0] right_hand;
        logic signed [SAMPLE_W-1:0] velocity;
        logic                       last_channel;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_intensity;
        logic signed [SAMPLE_W-1:0] mean_stokes_v;
        logic signed [SAMPLE_W-1:0] mean_left_hand;
        logic signed [SAMPLE_W-1:0] mean_right_hand;
        logic signed [SAMPLE_W-1:0] mean_velocity;
        logic [CNT_W-1:0]           channels_used;
    } t_out_item;

    // field 0 is intensity, the ranking key
    typedef logic [NFIELDS-1:0][SAMPLE_W-1:0] t_slot;

    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_entry;

    typedef struct packed {
        logic   take;
        t_entry entry;
    } t_link;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        t_slot [KEEP-1:0]     slot;
    } t_cap;

    function automatic logic [16:0] div3(input logic [17:0] x);
        logic [35:0] p;
        p = x * RECIP3;
        return p[35:RECIP3_SHIFT];
    endfunction

endpackage

FILE: rtl/tbc_cell.sv
// One slot of the sorted keep chain: compares the incoming channel, takes it or the
// entry shifted down from its upper neighbour. Depends on tbc_pkg.
module tbc_cell import tbc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_clr,
    input  logic   i_cand_en,
    input  t_slot  i_cand,
    input  t_link  i_up,
    output t_link  o_down,
    output t_entry o_next
);

    logic   r_valid;
    t_slot  r_slot;
    logic   w_take_here;
    t_entry n_entry;

    // later channel wins ties: take on equal intensity
    assign w_take_here = i_cand_en &&
        (!r_valid || ($signed(r_slot[F_INTENSITY]) <= $signed(i_cand[F_INTENSITY])));

    always_comb begin
        n_entry.valid = r_valid;
        n_entry.slot  = r_slot;
        if (i_up.take) begin
            n_entry = i_up.entry;
        end else if (w_take_here) begin
            n_entry.valid = 1'b1;
            n_entry.slot  = i_cand;
        end
    end

    assign o_down.take        = i_up.take || w_take_here;
    assign o_down.entry.valid = r_valid;
    assign o_down.entry.slot  = r_slot;
    assign o_next             = n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_entry.slot;
    end

endmodule

FILE: rtl/tbc_mean.sv
// Four-stage averaging pipe: capture, signed sum and magnitude, split divide by three,
// final quotient with sign. Depends on tbc_pkg.
module tbc_mean import tbc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cap      i_cap,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    // stage 1: capture
    logic                                r1_v;
    t_cap                                r1_cap;
    // stage 2: magnitude with rounding bias
    logic                                r2_v;
    logic [NFIELDS-1:0][32:0]            r2_mag;
    logic [NFIELDS-1:0]                  r2_neg;
    logic [CNT_W-1:0]                    r2_n;
    // stage 3: upper quotient digit
    logic                                r3_v;
    logic [NFIELDS-1:0][32:0]            r3_mag;
    logic [NFIELDS-1:0][15:0]            r3_qhi;
    logic [NFIELDS-1:0][1:0]             r3_rhi;
    logic [NFIELDS-1:0]                  r3_neg;
    logic [CNT_W-1:0]                    r3_n;
    // stage 4: output register
    logic                                r4_v;
    t_out_item                           r4_data;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic [NFIELDS-1:0][32:0]            n2_mag;
    logic [NFIELDS-1:0]                  n2_neg;
    logic [NFIELDS-1:0][15:0]            n3_qhi;
    logic [NFIELDS-1:0][1:0]             n3_rhi;
    logic [NFIELDS-1:0][SAMPLE_W-1:0]    n4_mean;

    assign w_rdy4  = !r4_v || !i_stall;
    assign w_rdy3  = !r3_v || w_rdy4;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r4_v;
    assign o_data  = r4_data;

    always_comb begin
        logic [33:0]         sum;
        logic [33:0]         mag;
        logic [SAMPLE_W-1:0] m;
        for (int f = 0; f < NFIELDS; f++) begin
            sum = '0;
            for (int k = 0; k < KEEP; k++) begin
                m = (CNT_W'(k) < r1_cap.count) ? r1_cap.slot[k][f] : '0;
                sum = sum + {{2{m[SAMPLE_W-1]}}, m};
            end
            n2_neg[f] = sum[33];
            mag       = sum[33] ? (34'd0 - sum) : sum;
            n2_mag[f] = mag[32:0] + 33'(r1_cap.count >= 2'd2);
        end
    end

    always_comb begin
        logic [16:0] hi;
        logic [16:0] q;
        logic [16:0] rem;
        for (int f = 0; f < NFIELDS; f++) begin
            hi        = r2_mag[f][32:16];
            q         = div3({1'b0, hi});
            rem       = hi - {q[15:0], 1'b0} - q;
            n3_qhi[f] = q[15:0];
            n3_rhi[f] = rem[1:0];
        end
    end

    always_comb begin
        logic [16:0] qlo;
        logic [32:0] q3;
        logic [32:0] q;
        logic [32:0] res;
        for (int f = 0; f < NFIELDS; f++) begin
            qlo = div3({r3_rhi[f], r3_mag[f][15:0]});
            q3  = {1'b0, r3_qhi[f], 16'd0} + {16'd0, qlo};
            case (r3_n)
                2'd3:    q = q3;
                2'd2:    q = {1'b0, r3_mag[f][32:1]};
                default: q = r3_mag[f];
            endcase
            res        = r3_neg[f] ? (33'd0 - q) : q;
            n4_mean[f] = res[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_cap <= i_cap;
        end
        if (w_rdy2 && r1_v) begin
            r2_mag <= n2_mag;
            r2_neg <= n2_neg;
            r2_n   <= r1_cap.count;
        end
        if (w_rdy3 && r2_v) begin
            r3_mag <= r2_mag;
            r3_qhi <= n3_qhi;
            r3_rhi <= n3_rhi;
            r3_neg <= r2_neg;
            r3_n   <= r2_n;
        end
        if (w_rdy4 && r3_v) begin
            r4_data.mean_intensity  <= n4_mean[F_INTENSITY];
            r4_data.mean_stokes_v   <= n4_mean[F_STOKES_V];
            r4_data.mean_left_hand  <= n4_mean[F_LEFT];
            r4_data.mean_right_hand <= n4_mean[F_RIGHT];
            r4_data.mean_velocity   <= n4_mean[F_VELOCITY];
            r4_data.channels_used   <= r3_n;
        end
    end

endmodule

FILE: rtl/top3_brightest_channel_mean_unit.sv
// Top level: channel counter, range registers, three-cell keep chain and averaging pipe.
// Depends on tbc_pkg, tbc_cell and tbc_mean.
// Throughput: one channel per cycle while o_stall is low; the three cells compare and shift
// in a single cycle. The last channel's result passes the four pipe stages to the output.
// Input stall rises only for a last channel while all four pipe stages hold a result and the
// output transfer is stalled.
// Reset: range 1..4096, all slots empty, channel counter at 1, pipe empty.
module top3_brightest_channel_mean_unit import tbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_data,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [CHAN_W-1:0] i_cfg_data
);

    logic [CHAN_W-1:0] r_first;
    logic [CHAN_W-1:0] r_final;
    logic [CHAN_W-1:0] r_chan;
    logic [CHAN_W-1:0] n_chan;

    logic              w_mean_ready;
    logic              w_acc;
    logic              w_last;
    logic              w_in_range;
    t_slot             w_cand;
    t_link             w_link [KEEP+1];
    t_entry            w_next [KEEP];
    logic [KEEP-1:0]   w_valid;
    logic [KEEP-1:0]   w_next_valid;
    t_cap              w_cap;

    assign o_stall    = i_data.last_channel && !w_mean_ready;
    assign w_acc      = i_valid && !o_stall;
    assign w_last     = w_acc && i_data.last_channel;
    assign w_in_range = (r_chan >= r_first) && (r_chan <= r_final) && (r_chan <= CHAN_MAX);

    assign w_cand[F_INTENSITY] = i_data.intensity;
    assign w_cand[F_STOKES_V]  = i_data.stokes_v;
    assign w_cand[F_LEFT]      = i_data.left_hand;
    assign w_cand[F_RIGHT]     = i_data.right_hand;
    assign w_cand[F_VELOCITY]  = i_data.velocity;

    assign w_link[0] = '0;

    for (genvar k = 0; k < KEEP; k++) begin : g_cell
        tbc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clr     (w_last),
            .i_cand_en (w_acc && w_in_range),
            .i_cand    (w_cand),
            .i_up      (w_link[k]),
            .o_down    (w_link[k+1]),
            .o_next    (w_next[k])
        );
        assign w_valid[k]      = w_link[k+1].entry.valid;
        assign w_next_valid[k] = w_next[k].valid;
        assign w_cap.slot[k]   = w_next[k].slot;
    end

    // slots fill from the brightest end, so the valid bits are a thermometer code
    assign w_cap.count = w_next_valid[2] ? 2'd3 :
                         w_next_valid[1] ? 2'd2 :
                         w_next_valid[0] ? 2'd1 : 2'd0;

    tbc_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_last),
        .o_ready (w_mean_ready),
        .i_cap   (w_cap),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always_comb begin
        n_chan = r_chan;
        if (w_last) begin
            n_chan = CHAN_ONE;
        end else if (w_acc && (r_chan < CHAN_STOP)) begin
            n_chan = r_chan + CHAN_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= CHAN_ONE;
        end else begin
            r_chan <= n_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= CHAN_ONE;
            r_final <= CHAN_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_CHANNEL: r_first <= i_cfg_data;
                CFG_FINAL_CHANNEL: r_final <= i_cfg_data;
                default:           r_first <= r_first;
            endcase
        end
    end

    a_chan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chan >= CHAN_ONE) && (r_chan <= CHAN_STOP))
        else $error("channel counter out of bounds");

    a_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid == 3'b000) || (w_valid == 3'b001) || (w_valid == 3'b011) ||
        (w_valid == 3'b111))
        else $error("kept slots not filled from the top");

    a_epoch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last |=> (w_valid == 3'b000) && (r_chan == CHAN_ONE))
        else $error("epoch state not cleared after last channel");

    a_stall_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_data.last_channel)
        else $error("stall raised for a non-final channel");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_link[KEEP].take && (w_valid == 3'b111)) |-> w_link[KEEP].entry.valid)
        else $error("full chain took a channel without dropping a kept one");

endmodule
